// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge once out of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication checked at the next edge
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/pla_pkg.sv =====
// ----------------------------------------------------------------------------
// pla_pkg
// shared constants and types for the point light accumulator
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int unsigned LightSlots = 64;
  localparam int unsigned SlotW      = $clog2(LightSlots);
  localparam int unsigned CountW     = $clog2(LightSlots + 1);

  localparam logic [1:0] ReqReserve = 2'd0;
  localparam logic [1:0] ReqCommit  = 2'd1;
  localparam logic [1:0] ReqQuery   = 2'd2;

  localparam logic [7:0] AmbientReset = 8'd25;

  typedef struct packed {
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } light_pos_t;

  typedef struct packed {
    logic [7:0]  col_b;
    logic [7:0]  col_g;
    logic [7:0]  col_r;
    logic [15:0] radius;
  } light_shape_t;

  // handshake between the sequencer and the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

// ===== rtl/core/pla_divider.sv =====
// ----------------------------------------------------------------------------
// pla_divider
// radix-2 restoring divider, one quotient bit per cycle; also serves the
// integer square root by one result bit per cycle when sqrt_i is set; den may be zero
// ----------------------------------------------------------------------------
module pla_divider import pla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  input  logic        sqrt_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [31:0] den_q, den_d;
  logic        sqrt_q, sqrt_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [65:0] trial;
  logic [63:0] rem_sh;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    num_d  = num_q;
    den_d  = den_q;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = '0;
    rem_sh = '0;
    if (busy_q) begin
      if (sqrt_q) begin
        // two radicand bits in, trial 4*root+1
        rem_sh = {rem_q[61:0], num_q[63:62]};
        trial  = {2'b0, rem_sh} - {quo_q[63:0], 2'b01};
        num_d  = {num_q[61:0], 2'b00};
        if (!trial[65]) begin
          rem_d = trial[63:0];
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd31) begin
          busy_d = 1'b0;
          done_o = 1'b1;
        end
      end else begin
        rem_sh = {rem_q[62:0], num_q[63]};
        trial  = {2'b0, rem_sh} - {34'd0, den_q};
        num_d  = {num_q[62:0], 1'b0};
        if (!trial[65]) begin
          rem_d = trial[63:0];
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_d = 1'b0;
          done_o = 1'b1;
        end
      end
    end
    // result of the final step, seen before a new start is loaded
    quot_o = quo_d;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      sqrt_d = sqrt_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    num_q  <= num_d;
    den_q  <= den_d;
    sqrt_q <= sqrt_d;
  end

endmodule

// ===== rtl/core/point_light_accumulator.sv =====
// ----------------------------------------------------------------------------
// point_light_accumulator
// 2d point lights with linear falloff, pending/active light lists
// ----------------------------------------------------------------------------
// A reserve request is written to the pending list if not full, without
// leaving StIdle. A commit copies each pending light through StCopyR and
// StCopyW and then returns to StIdle. A query reads and tests each active
// light in StRead, StLoad and StTest and skips one out of reach or of zero
// radius; a light in reach takes a 32-step square root and a 64-step divide
// on the shared bit-serial divider and a per-channel accumulation in StAcc.
// The final scaling is done in StScale and the output in StOut. One request
// is worked on at a time; a finished result waits in an output register, so
// the next request can be taken meanwhile, and a query only stalls at its
// end while the previous result is still waiting.
module point_light_accumulator import pla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // pos_x[15:0], pos_y[31:16], radius[47:32], color_r[55:48],
  // color_g[63:56], color_b[71:64], color_a[79:72]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_r[7:0], out_g[15:8], out_b[23:16], out_a[31:24]
  output logic [31:0] m_axis_tdata
);
`include "assert_macros.svh"

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCopyR = 4'd1;
  localparam logic [3:0] StCopyW = 4'd2;
  localparam logic [3:0] StRead  = 4'd3;
  localparam logic [3:0] StTest  = 4'd4;
  localparam logic [3:0] StSqrt  = 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;
  localparam logic [3:0] StAcc   = 4'd7;
  localparam logic [3:0] StScale = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StLoad  = 4'd10;

  logic [1:0]  req_type;
  logic [15:0] in_x, in_y, in_rad;
  logic [7:0]  in_r, in_g, in_b, in_a;
  assign req_type = s_axis_tuser;
  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign in_rad   = s_axis_tdata[47:32];
  assign in_r     = s_axis_tdata[55:48];
  assign in_g     = s_axis_tdata[63:56];
  assign in_b     = s_axis_tdata[71:64];
  assign in_a     = s_axis_tdata[79:72];

  light_pos_t   pend_pos_mem [LightSlots];
  light_shape_t pend_shp_mem [LightSlots];
  light_pos_t   act_pos_mem  [LightSlots];
  light_shape_t act_shp_mem  [LightSlots];

  logic [3:0]        st_q, st_d;
  logic [CountW-1:0] pend_cnt_q, pend_cnt_d, act_cnt_q, act_cnt_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [7:0]        amb_q;
  logic [15:0]       qx_q, qx_d, qy_q, qy_d;
  logic [7:0]        own_r_q, own_r_d, own_g_q, own_g_d, own_b_q, own_b_d;
  logic [7:0]        own_a_q, own_a_d;
  logic [7:0]        sum_r_q, sum_r_d, sum_g_q, sum_g_d, sum_b_q, sum_b_d;
  logic [16:0]       wt_q, wt_d;
  logic [23:0]       pix_q, pix_d;
  logic              ovld_q, ovld_d;
  logic [31:0]       odata_q, odata_d;
  logic [1:0]        ch_q, ch_d;

  light_pos_t   pend_pos_rd, act_pos_rd;
  light_shape_t pend_shp_rd, act_shp_rd;
  logic         pend_wr, act_wr;
  logic [SlotW-1:0] rd_addr;

  div_req_t     dreq;
  logic         dsqrt, ddone;
  logic [63:0]  dquot;

  logic         in_acc;
  logic signed [16:0] dx, dy;
  logic [33:0]  sq_full;
  logic [31:0]  rr;
  logic [7:0]   lc, own_c, sum_c;
  logic [24:0]  prod;
  logic [8:0]   addv;
  logic [15:0]  scl;
  logic [7:0]   scaled;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign rd_addr       = idx_q[SlotW-1:0];

  // memories: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (pend_wr) begin
      pend_pos_mem[pend_cnt_q[SlotW-1:0]] <= '{pos_y: in_y, pos_x: in_x};
      pend_shp_mem[pend_cnt_q[SlotW-1:0]] <=
        '{col_b: in_b, col_g: in_g, col_r: in_r, radius: in_rad};
    end
    pend_pos_rd <= pend_pos_mem[rd_addr];
    pend_shp_rd <= pend_shp_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (act_wr) begin
      act_pos_mem[rd_addr] <= pend_pos_rd;
      act_shp_mem[rd_addr] <= pend_shp_rd;
    end
    act_pos_rd <= act_pos_mem[rd_addr];
    act_shp_rd <= act_shp_mem[rd_addr];
  end

  pla_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .sqrt_i (dsqrt),
    .done_o (ddone),
    .quot_o (dquot)
  );

  assign dx      = $signed({qx_q[15], qx_q}) - $signed({act_pos_rd.pos_x[15], act_pos_rd.pos_x});
  assign dy      = $signed({qy_q[15], qy_q}) - $signed({act_pos_rd.pos_y[15], act_pos_rd.pos_y});
  assign sq_full = {1'b0, 33'(dx * dx)} + {1'b0, 33'(dy * dy)};
  assign rr      = act_shp_rd.radius * act_shp_rd.radius;

  always_comb begin
    case (ch_q)
      2'd0: begin lc = act_shp_rd.col_r; own_c = own_r_q; sum_c = sum_r_q; end
      2'd1: begin lc = act_shp_rd.col_g; own_c = own_g_q; sum_c = sum_g_q; end
      default: begin lc = act_shp_rd.col_b; own_c = own_b_q; sum_c = sum_b_q; end
    endcase
  end

  assign prod = lc * wt_q;
  assign addv = {1'b0, sum_c} + {1'b0, prod[23:16]};
  // divide by 255: x/255 = (x + (x>>8) + 1) >> 8 for x < 65535
  assign scl    = sum_c * own_c;
  assign scaled = 8'((17'(scl) + 17'(scl[15:8]) + 17'd1) >> 8);

  always_comb begin
    st_d = st_q; pend_cnt_d = pend_cnt_q; act_cnt_d = act_cnt_q; idx_d = idx_q;
    qx_d = qx_q; qy_d = qy_q; own_r_d = own_r_q; own_g_d = own_g_q;
    own_b_d = own_b_q; own_a_d = own_a_q; sum_r_d = sum_r_q; sum_g_d = sum_g_q;
    sum_b_d = sum_b_q; wt_d = wt_q; pix_d = pix_q; ch_d = ch_q;
    ovld_d = ovld_q; odata_d = odata_q;
    pend_wr = 1'b0; act_wr = 1'b0;
    dreq = '0; dsqrt = 1'b0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          case (req_type)
            ReqReserve: begin
              if (pend_cnt_q < CountW'(LightSlots)) begin
                pend_wr    = 1'b1;
                pend_cnt_d = pend_cnt_q + CountW'(1);
              end
            end
            ReqCommit: begin
              idx_d = '0;
              st_d  = StCopyR;
            end
            ReqQuery: begin
              qx_d = in_x; qy_d = in_y;
              own_r_d = in_r; own_g_d = in_g; own_b_d = in_b; own_a_d = in_a;
              sum_r_d = amb_q; sum_g_d = amb_q; sum_b_d = amb_q;
              idx_d = '0;
              st_d  = StRead;
            end
            default: ;
          endcase
        end
      end
      StCopyR: begin
        if (idx_q == pend_cnt_q) begin
          act_cnt_d  = pend_cnt_q;
          pend_cnt_d = '0;
          st_d       = StIdle;
        end else begin
          st_d = StCopyW;
        end
      end
      StCopyW: begin
        act_wr = 1'b1;
        idx_d  = idx_q + CountW'(1);
        st_d   = StCopyR;
      end
      StRead: begin
        if (idx_q == act_cnt_q) begin
          ch_d = 2'd0;
          st_d = StScale;
        end else begin
          st_d = StLoad;
        end
      end
      StLoad: st_d = StTest;
      StTest: begin
        if (act_shp_rd.radius == 16'd0 || sq_full > {2'b0, rr}) begin
          idx_d = idx_q + CountW'(1);
          st_d  = StRead;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = {sq_full[31:0], 32'd0};
          dsqrt      = 1'b1;
          st_d       = StSqrt;
        end
      end
      StSqrt: begin
        if (ddone) begin
          dreq.start = 1'b1;
          dreq.num   = {32'd0, dquot[31:0]};
          dreq.den   = {16'd0, act_shp_rd.radius};
          st_d       = StDiv;
        end
      end
      StDiv: begin
        if (ddone) begin
          if (dquot > 64'd65536) wt_d = '0;
          else wt_d = 17'd65536 - 17'(dquot);
          ch_d = 2'd0;
          st_d = StAcc;
        end
      end
      StAcc: begin
        case (ch_q)
          2'd0: sum_r_d = addv[8] ? 8'd255 : addv[7:0];
          2'd1: sum_g_d = addv[8] ? 8'd255 : addv[7:0];
          default: sum_b_d = addv[8] ? 8'd255 : addv[7:0];
        endcase
        if (ch_q == 2'd2) begin
          idx_d = idx_q + CountW'(1);
          st_d  = StRead;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      StScale: begin
        case (ch_q)
          2'd0: pix_d[7:0]   = scaled;
          2'd1: pix_d[15:8]  = scaled;
          default: pix_d[23:16] = scaled;
        endcase
        if (ch_q == 2'd2) st_d = StOut;
        else ch_d = ch_q + 2'd1;
      end
      StOut: begin
        // wait while the previous result is still held
        if (!ovld_q || m_axis_tready) begin
          odata_d = {own_a_q, pix_q};
          ovld_d  = 1'b1;
          st_d    = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pend_cnt_q <= '0; act_cnt_q <= '0; ovld_q <= 1'b0;
      amb_q <= AmbientReset;
    end else begin
      st_q <= st_d; pend_cnt_q <= pend_cnt_d; act_cnt_q <= act_cnt_d;
      ovld_q <= ovld_d;
      if (cfg_valid_i) amb_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; qx_q <= qx_d; qy_q <= qy_d;
    own_r_q <= own_r_d; own_g_q <= own_g_d; own_b_q <= own_b_d; own_a_q <= own_a_d;
    sum_r_q <= sum_r_d; sum_g_q <= sum_g_d; sum_b_q <= sum_b_d;
    wt_q <= wt_d; pix_q <= pix_d; ch_q <= ch_d; odata_q <= odata_d;
  end

  `ASSERT_CLK(a_cnt_range, pend_cnt_q <= CountW'(LightSlots) && act_cnt_q <= CountW'(LightSlots))
  `ASSERT_NEXT(a_hold_out, ovld_q && !m_axis_tready, ovld_q && $stable(odata_q))
  `ASSERT_NEXT(a_busy_after_query, in_acc && req_type == ReqQuery, st_q == StRead)

endmodule

// ===== sim/tb_point_light_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_point_light_accumulator
// self-checking bench for the point light accumulator
// ----------------------------------------------------------------------------
// Drives reserve, commit, query and unused requests over the input stream and keeps
// its own copy of the pending and active light lists. Each query is shaded
// in the bench with the same integer falloff as the block and compared with
// the result stream. The ambient level is rewritten between phases while idle.
module tb_point_light_accumulator;
  import pla_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] rad;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
  } light_req_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  point_light_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // bench copy of the light lists
  light_pos_t   pend_pos [LightSlots];
  light_shape_t pend_shape [LightSlots];
  int unsigned  pend_count;
  light_pos_t   act_pos [LightSlots];
  light_shape_t act_shape [LightSlots];
  int unsigned  act_count;
  logic [7:0]   ambient;

  pixel_t      shade_q [$];
  int unsigned fail_count;
  int unsigned req_count;
  int unsigned pixel_count;
  int unsigned dropped_count;
  bit          sender_idles;
  bit          receiver_idles;
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2000000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic pixel_t shade_point(input light_req_t q);
    int unsigned sum [3];
    logic [7:0]  own [3];
    longint      dx;
    longint      dy;
    logic [63:0] sq;
    logic [63:0] rr;
    logic [63:0] ratio;
    logic [63:0] weight;
    logic [7:0]  lc;
    pixel_t      p;
    own[0] = q.r;
    own[1] = q.g;
    own[2] = q.b;
    for (int c = 0; c < 3; c++) sum[c] = ambient;
    for (int i = 0; i < act_count; i++) begin
      rr = act_shape[i].radius;
      if (rr == 0) continue;
      dx = longint'($signed(q.x)) - longint'($signed(act_pos[i].pos_x));
      dy = longint'($signed(q.y)) - longint'($signed(act_pos[i].pos_y));
      sq = dx * dx + dy * dy;
      if (sq > rr * rr) continue;
      ratio = root_floor(sq << 32) / rr;
      if (ratio > 65536) ratio = 65536;
      weight = 65536 - ratio;
      for (int c = 0; c < 3; c++) begin
        lc = (c == 0) ? act_shape[i].col_r : (c == 1) ? act_shape[i].col_g
                                                       : act_shape[i].col_b;
        sum[c] += int'((64'(lc) * weight) >> 16);
        if (sum[c] > 255) sum[c] = 255;
      end
    end
    p.r = 8'((sum[0] * own[0]) / 255);
    p.g = 8'((sum[1] * own[1]) / 255);
    p.b = 8'((sum[2] * own[2]) / 255);
    p.a = q.a;
    return p;
  endfunction

  task automatic apply_request(input light_req_t q);
    case (q.kind)
      ReqReserve: begin
        if (pend_count < LightSlots) begin
          pend_pos[pend_count] = '{pos_y: q.y, pos_x: q.x};
          pend_shape[pend_count] = '{col_b: q.b, col_g: q.g, col_r: q.r, radius: q.rad};
          pend_count++;
        end else begin
          dropped_count++;
        end
      end
      ReqCommit: begin
        for (int i = 0; i < pend_count; i++) begin
          act_pos[i] = pend_pos[i];
          act_shape[i] = pend_shape[i];
        end
        act_count = pend_count;
        pend_count = 0;
      end
      ReqQuery: begin
        shade_q.push_back(shade_point(q));
      end
      default: ;
    endcase
  endtask

  function automatic light_req_t make_req(input logic [1:0] kind, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] rad,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a);
    make_req = '{kind: kind, x: x, y: y, rad: rad, r: r, g: g, b: b, a: a};
  endfunction

  // tvalid stays high once taken; the next call may drop it, drain_results does
  task automatic send_request(input light_req_t q);
    @(negedge clk_i);
    while (sender_idles && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.kind;
    s_axis_tdata  <= {q.a, q.b, q.g, q.r, q.rad, q.y, q.x};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(q);
    req_count++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ambient(input logic [7:0] level);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= level;
    do @(posedge clk_i); while (!cfg_ready_o);
    ambient = level;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result stream checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (shade_q.size() == 0) begin
        $display("unexpected result %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = shade_q.pop_front();
        pixel_count++;
        if (m_axis_tdata[7:0] !== want.r) report("red", m_axis_tdata[7:0], want.r);
        if (m_axis_tdata[15:8] !== want.g) report("green", m_axis_tdata[15:8], want.g);
        if (m_axis_tdata[23:16] !== want.b) report("blue", m_axis_tdata[23:16], want.b);
        if (m_axis_tdata[31:24] !== want.a) report("alpha", m_axis_tdata[31:24], want.a);
      end
    end
  end

  // receiver back-pressure, long hold-offs counted here
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= !receiver_idles || ($urandom_range(99) >= 21);
    end
  end

  function automatic light_req_t random_light(input bit wide);
    light_req_t q;
    q = make_req(ReqReserve, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
    if (!wide) begin
      q.x = 16'($signed($urandom_range(400)) - 200);
      q.y = 16'($signed($urandom_range(400)) - 200);
      q.rad = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(500));
    end
    return q;
  endfunction

  function automatic light_req_t random_query(input bit wide);
    light_req_t q;
    q = random_light(wide);
    q.kind = ReqQuery;
    return q;
  endfunction

  task automatic test_directed();
    // empty list gives ambient scaled by own colour
    send_request(make_req(ReqQuery, 16'd0, 16'd0, 16'd0, 8'd255, 8'd128, 8'd0, 8'd77));
    send_request(make_req(ReqReserve, 16'd0, 16'd0, 16'd5, 8'd200, 8'd100, 8'd255, 8'd0));
    send_request(make_req(ReqReserve, 16'd10, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd0));
    send_request(make_req(ReqReserve, 16'h8000, 16'h8000, 16'hffff, 8'd255, 8'd255, 8'd255,
                          8'hff));
    send_request(make_req(ReqReserve, 16'h7fff, 16'h7fff, 16'hffff, 8'd1, 8'd0, 8'd254, 8'd0));
    // still pending, so ambient only
    send_request(make_req(ReqQuery, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255));
    send_request(make_req(ReqCommit, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_request(make_req(ReqQuery, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd0));
    // exactly on the radius edge
    send_request(make_req(ReqQuery, 16'd3, 16'd4, 16'd0, 8'd255, 8'd255, 8'd255, 8'd1));
    send_request(make_req(ReqQuery, 16'd10, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd2));
    send_request(make_req(ReqQuery, 16'h8000, 16'h8000, 16'h0, 8'd255, 8'd255, 8'd255, 8'd3));
    send_request(make_req(ReqQuery, 16'h7fff, 16'h7fff, 16'h0, 8'd0, 8'd0, 8'd0, 8'd4));
    send_request(make_req(ReqQuery, 16'h7fff, 16'h8000, 16'hffff, 8'd17, 8'd255, 8'd99,
                          8'd5));
    // unused request code changes nothing
    send_request(make_req(ReqUnused, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1, 8'd1, 8'd1));
    send_request(make_req(ReqQuery, 16'd1, 16'd1, 16'd0, 8'd255, 8'd255, 8'd255, 8'd6));
    // empty commit clears the active list
    send_request(make_req(ReqCommit, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(ReqQuery, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd7));
  endtask

  task automatic test_full_list();
    // overfill so the extra reserves are dropped, all lights near the origin
    for (int i = 0; i < LightSlots + 4; i++) send_request(random_light(1'b0));
    send_request(make_req(ReqCommit, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    repeat (3) send_request(random_query(1'b0));
  endtask

  task automatic test_backpressure();
    send_request(make_req(ReqReserve, 16'd0, 16'd0, 16'd300, 8'd90, 8'd60, 8'd30, 8'd0));
    send_request(make_req(ReqCommit, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    hold_cycles = 2000;
    repeat (12) send_request(random_query(1'b0));
    drain_results();
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned k;
    stop_at = req_count + count;
    while (req_count < stop_at) begin
      k = ($urandom_range(29) == 0) ? $urandom_range(LightSlots + 6) : $urandom_range(6);
      for (int i = 0; i < k; i++) send_request(random_light($urandom_range(9) == 0));
      if ($urandom_range(9) != 0)
        send_request(make_req(ReqCommit, 16'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      k = (act_count > 16) ? $urandom_range(2) : $urandom_range(8, 1);
      for (int i = 0; i < k; i++) send_request(random_query($urandom_range(7) == 0));
      if ($urandom_range(14) == 0)
        send_request(make_req(ReqUnused, 16'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    pend_count = 0;
    act_count = 0;
    ambient = AmbientReset;
    fail_count = 0;
    req_count = 0;
    pixel_count = 0;
    dropped_count = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hold_cycles = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    write_ambient(8'd255);
    test_directed();
    write_ambient(8'd0);
    test_full_list();
    test_backpressure();
    write_ambient(8'd25);
    // a stretch with no idling on either side
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random(300);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    write_ambient(8'($urandom));
    test_random(500);
    write_ambient(8'd128);
    test_random(450);
    drain_results();

    $display("%0d requests sent, %0d shaded pixels checked, %0d reserves dropped on a full list",
             req_count, pixel_count, dropped_count);
    $display("ambient levels 0, 25, 128, 255 and random, with stalls on both streams");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== point_light_accumulator.f =====
+incdir+rtl/core
rtl/core/pla_pkg.sv
rtl/core/pla_divider.sv
rtl/core/point_light_accumulator.sv
sim/tb_point_light_accumulator.sv
